// ===== rtl/byte_ring_fifo_macros.svh =====
// Assertion macros shared by the byte ring FIFO checker.
`ifndef BYTE_RING_FIFO_MACROS_SVH
`define BYTE_RING_FIFO_MACROS_SVH

// Same-cycle implication, sampled on aclk and idle while aresetn is low.
`define BRF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and idle while aresetn is low.
`define BRF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/brf_pkg.sv =====
// Types and constants of the byte ring FIFO.
`default_nettype none

package brf_pkg;

    localparam int OP_W      = 2;
    localparam int DATA_W    = 8;
    localparam int FILL_W    = 6;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_FLUSH = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/brf_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/byte_ring_fifo.sv =====
// Byte ring FIFO: a circular byte store with push, pop, peek and flush items.
//
// Usage. Each item on the slave channel (s_tvalid, s_tready, s_tdata) carries
// an operation and a byte; each item gives exactly one result item on the
// master channel (m_tvalid, m_tready, m_tdata), in order. The store holds at
// most DEPTH-1 bytes so that equal pointers mean empty. A push into a full
// store drops the byte and flags it; a pop or peek of an empty store flags
// that and returns zero. Every result reports the fill count after the item.
//
// Throughput. A push or a flush shows its result in the cycle after
// acceptance, so these run at one item per cycle while each result is taken.
// A pop or a peek passes the store read register and then the output register,
// as the byte comes from the synchronous store memory; no item is taken meanwhile.
//
// Reset. aresetn (synchronous, active low) empties the FIFO by clearing both
// pointers and drops any result that is waiting. The memory is not cleared;
// the pointer rules never let an unwritten slot be read.
//
// Back-pressure. The result sits in an output register; while the receiver
// holds m_tready low it stays there and no new item is accepted, except when
// the waiting result is taken in the same cycle.
`default_nettype none

module byte_ring_fifo #(
    parameter int DEPTH = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata, from bit 0: operation[1:0], data_in[9:2], zero padding[15:10].
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [brf_pkg::S_TDATA_W-1:0]  s_tdata,
    // m_tdata, from bit 0: data_out[7:0], was_empty[8], dropped[9],
    // fill_count[15:10].
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [brf_pkg::M_TDATA_W-1:0]  m_tdata
);

    import brf_pkg::*;

    localparam int AW = $clog2(DEPTH);

    state_t              state_reg, state_next;
    logic [AW-1:0]       wp_reg, wp_next;
    logic [AW-1:0]       rp_reg, rp_next;
    logic                rd_empty_reg, rd_empty_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                s_accept;
    op_t                 op;
    logic [DATA_W-1:0]   din;
    logic [AW-1:0]       wp_inc, rp_inc;
    logic                is_empty, is_full;
    logic                ram_we, ram_re;
    logic [DATA_W-1:0]   ram_rdata;

    logic                res_load;
    logic [DATA_W-1:0]   res_data;
    logic                res_empty;
    logic                res_drop;
    logic [AW:0]         cnt_diff, cnt_mod;

    // Pointers advance and wrap at DEPTH-1, so any depth works, not only powers of two.
    assign wp_inc   = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc   = (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign is_empty = (wp_reg == rp_reg);
    assign is_full  = (wp_inc == rp_reg);

    assign op       = op_t'(s_tdata[OP_W-1:0]);
    assign din      = s_tdata[OP_W +: DATA_W];
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        rd_empty_next = rd_empty_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        res_load      = 1'b0;
        res_data      = '0;
        res_empty     = 1'b0;
        res_drop      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (op)
                        OP_PUSH: begin
                            res_load = 1'b1;
                            res_drop = is_full;
                            if (!is_full) begin
                                ram_we  = 1'b1;
                                wp_next = wp_inc;
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            // The byte comes next cycle; the read pointer moves now.
                            ram_re        = 1'b1;
                            rd_empty_next = is_empty;
                            state_next    = ST_READ;
                            if (!is_empty && (op == OP_POP)) begin
                                rp_next = rp_inc;
                            end
                        end
                        OP_FLUSH: begin
                            res_load = 1'b1;
                            wp_next  = '0;
                            rp_next  = '0;
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_load   = 1'b1;
                res_empty  = rd_empty_reg;
                res_data   = rd_empty_reg ? '0 : ram_rdata;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Fill count after the item: (write - read) modulo DEPTH, low bits kept.
    assign cnt_diff = {1'b0, wp_next} - {1'b0, rp_next};
    assign cnt_mod  = (wp_next >= rp_next) ? cnt_diff : cnt_diff + (AW + 1)'(DEPTH);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {FILL_W'(cnt_mod), res_drop, res_empty, res_data};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            rp_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_empty_reg <= rd_empty_next;
        m_data_reg   <= m_data_next;
    end

    brf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg),
        .wr_data (din),
        .rd_en   (ram_re),
        .rd_addr (rp_reg),
        .rd_data (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/brf_checker.sv =====
// Port-level checker for the byte ring FIFO and its bind to the top level.
`default_nettype none
`include "byte_ring_fifo_macros.svh"

module brf_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [brf_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [brf_pkg::M_TDATA_W-1:0] m_tdata
);

    import brf_pkg::*;

    `BRF_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `BRF_ASSERT_IMP(a_flags_apart, m_tvalid, !(m_tdata[8] && m_tdata[9]), "empty and drop flagged together")
    `BRF_ASSERT_IMP(a_empty_fill, m_tvalid && m_tdata[8], m_tdata[15:10] == 6'd0, "empty result with nonzero fill")
    `BRF_ASSERT_NXT(a_flush_result, s_tvalid && s_tready && (s_tdata[1:0] == OP_FLUSH), m_tvalid && (m_tdata == 16'd0), "flush result not all zero")
    `BRF_ASSERT_NXT(a_push_result, s_tvalid && s_tready && (s_tdata[1:0] == OP_PUSH), m_tvalid && !m_tdata[8], "push result missing")

endmodule

bind byte_ring_fifo brf_checker u_brf_checker (.*);

`default_nettype wire
